@@ rtl/core/rcc_pkg.sv @@
package rcc_pkg;

    localparam int MAX_RECORD_BYTES = 256;
    localparam int POS_W = $clog2(MAX_RECORD_BYTES);
    localparam int OFFSET_W = 8;
    localparam int CMP_W = (POS_W > OFFSET_W) ? POS_W : OFFSET_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_RECORD_BYTES - 1);

    localparam int CRC_W = 32;
    localparam int FIELD_BYTES = 4;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam int ADDR_W = 3;
    localparam logic REG_CHECKSUM_OFFSET = 1'b0;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } step_ctrl_t;

    typedef struct packed {
        logic [CRC_W-1:0] crc;
        logic [CRC_W-1:0] stored;
        logic             ok;
    } result_t;

    localparam logic [CRC_W-1:0] NIB_TABLE [16] = '{
        32'h00000000, 32'h1db71064, 32'h3b6e20c8, 32'h26d930ac,
        32'h76dc4190, 32'h6b6b51f4, 32'h4db26158, 32'h5005713c,
        32'hedb88320, 32'hf00f9344, 32'hd6d6a3e8, 32'hcb61b38c,
        32'h9b64c2b0, 32'h86d3d2d4, 32'ha00ae278, 32'hbdbdf21c
    };

    function automatic logic [CRC_W-1:0] crc_nibble(input logic [CRC_W-1:0] crc,
                                                    input logic [3:0] nib);
        logic [3:0] idx;
        idx = crc[3:0] ^ nib;
        return NIB_TABLE[idx] ^ (crc >> 4);
    endfunction

endpackage

@@ rtl/core/rcc_crc_byte.sv @@
module rcc_crc_byte (
    input  logic [rcc_pkg::CRC_W-1:0] crc_in,
    input  logic [7:0]                data_in,
    output logic [rcc_pkg::CRC_W-1:0] crc_out
);

    logic [rcc_pkg::CRC_W-1:0] crc_mid;

    // Low nibble first, then high nibble.
    assign crc_mid = rcc_pkg::crc_nibble(crc_in, data_in[3:0]);
    assign crc_out = rcc_pkg::crc_nibble(crc_mid, data_in[7:4]);

endmodule

@@ rtl/core/rcc_record_state.sv @@
module rcc_record_state (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rcc_pkg::step_ctrl_t          step,
    input  logic [7:0]                   data_byte,
    input  logic [rcc_pkg::OFFSET_W-1:0] checksum_offset,
    output rcc_pkg::result_t             result
);

    logic [rcc_pkg::CRC_W-1:0] crc_reg, crc_next;
    logic [rcc_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [rcc_pkg::CRC_W-1:0] cap_reg, cap_next;

    logic [rcc_pkg::CRC_W-1:0] crc_base, crc_upd, cap_base, cap_upd;
    logic [rcc_pkg::POS_W-1:0] pos_base, pos_upd;
    logic [rcc_pkg::CMP_W-1:0] pos_ext, off_ext, diff;
    logic                      in_field;
    logic [7:0]                fed;
    logic [1:0]                lane;

    always_comb begin
        crc_base = step.first ? rcc_pkg::CRC_INIT : crc_reg;
        pos_base = step.first ? '0 : pos_reg;
        cap_base = step.first ? '0 : cap_reg;
    end

    assign pos_ext  = rcc_pkg::CMP_W'(pos_base);
    assign off_ext  = rcc_pkg::CMP_W'(checksum_offset);
    assign diff     = pos_ext - off_ext;
    assign in_field = (pos_ext >= off_ext)
                      && (diff < rcc_pkg::CMP_W'(rcc_pkg::FIELD_BYTES));
    assign lane     = diff[1:0];
    assign fed      = in_field ? 8'h00 : data_byte;

    always_comb begin
        cap_upd = cap_base;
        if (in_field) begin
            cap_upd[8*lane +: 8] = data_byte;
        end
    end

    rcc_crc_byte u_crc_byte (
        .crc_in  (crc_base),
        .data_in (fed),
        .crc_out (crc_upd)
    );

    assign pos_upd = (pos_base < rcc_pkg::POS_MAX) ? pos_base + 1'b1 : pos_base;

    always_comb begin
        crc_next = crc_reg;
        pos_next = pos_reg;
        cap_next = cap_reg;
        if (step.valid) begin
            if (step.last) begin
                crc_next = rcc_pkg::CRC_INIT;
                pos_next = '0;
                cap_next = '0;
            end else begin
                crc_next = crc_upd;
                pos_next = pos_upd;
                cap_next = cap_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= rcc_pkg::CRC_INIT;
            pos_reg <= '0;
            cap_reg <= '0;
        end else begin
            crc_reg <= crc_next;
            pos_reg <= pos_next;
            cap_reg <= cap_next;
        end
    end

    always_comb begin
        result.crc    = ~crc_upd;
        result.stored = cap_upd;
        result.ok     = (~crc_upd == cap_upd);
    end

endmodule

@@ rtl/core/record_crc32_checker.sv @@
// Each byte is registered in the input stage; each result in the result register.
// Throughput: one byte per cycle while the result side is not stalled.
// Only a byte marked last waits for space in the result register.
// Reset is synchronous on aresetn low: input and result stages empty, the CRC, position
// and captured checksum return to their start values and checksum_offset to zero.
module record_crc32_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,  // [7:0] data_byte
    input  logic                       s_tuser,  // [0] first_byte
    input  logic                       s_tlast,  // last_byte
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [63:0]                m_tdata,  // [31:0] crc_value, [63:32] stored_checksum
    output logic                       m_tuser,  // [0] checksum_ok
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rcc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    logic                         offset_wr;
    logic [rcc_pkg::OFFSET_W-1:0] offset_reg, offset_next;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg, in_byte_next;
    logic       in_first_reg, in_first_next;
    logic       in_last_reg, in_last_next;

    logic        out_valid_reg, out_valid_next;
    logic [63:0] out_data_reg, out_data_next;
    logic        out_ok_reg, out_ok_next;

    logic                out_free, advance, s_take;
    rcc_pkg::step_ctrl_t step;
    rcc_pkg::result_t    result;

    assign pready    = 1'b1;
    assign offset_wr = psel && penable && pwrite && pready
                       && (paddr[rcc_pkg::ADDR_W-1] == rcc_pkg::REG_CHECKSUM_OFFSET);
    assign offset_next = offset_wr ? pwdata[rcc_pkg::OFFSET_W-1:0] : offset_reg;
    assign prdata = (paddr[rcc_pkg::ADDR_W-1] == rcc_pkg::REG_CHECKSUM_OFFSET)
                    ? 32'(offset_reg) : 32'h0;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_take   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        in_first_next = in_first_reg;
        in_last_next  = in_last_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
            in_first_next = s_tuser;
            in_last_next  = s_tlast;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        step.valid = advance;
        step.first = in_first_reg;
        step.last  = in_last_reg;
    end

    rcc_record_state u_record_state (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (step),
        .data_byte       (in_byte_reg),
        .checksum_offset (offset_reg),
        .result          (result)
    );

    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_ok_next    = out_ok_reg;
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
            out_data_next  = {result.stored, result.crc};
            out_ok_next    = result.ok;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg    <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            offset_reg    <= offset_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_byte_reg  <= in_byte_next;
        in_first_reg <= in_first_next;
        in_last_reg  <= in_last_next;
        out_data_reg <= out_data_next;
        out_ok_reg   <= out_ok_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

endmodule

@@ rtl/core/rcc_checker.sv @@
module rcc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser,
    input logic [31:0] prdata,
    input logic        pready
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_ok_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == (m_tdata[31:0] == m_tdata[63:32])))
        else $error("checksum_ok disagrees with the CRC and stored checksum");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_prdata_width: assert property (@(posedge aclk) disable iff (!aresetn)
        pready |-> (prdata[31:rcc_pkg::OFFSET_W] == '0))
        else $error("register read returned bits above checksum_offset");

endmodule

bind record_crc32_checker rcc_checker u_rcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .prdata   (prdata),
    .pready   (pready)
);
